@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL of the segment cut counter.
// Depends on nothing; the including module supplies clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, idle while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Clocked implication, idle while reset is high.
`define ASSERT_IMP(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

`endif

@@ sv/mscc_pkg.sv @@
// Package of the segment cut counter: sequencer states, register codes, field widths.
// Depends on nothing.
package mscc_pkg;

   localparam int FIELD_W = 13;
   localparam int DATA_W  = 16;
   localparam int CSR_IDX_W = 2;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_PIECE_LEN_A = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PIECE_LEN_B = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PIECE_LEN_C = 2'd2;

   // Reset values of the piece lengths
   localparam logic [FIELD_W-1:0] LEN_A_RESET = 13'd1;
   localparam logic [FIELD_W-1:0] LEN_B_RESET = 13'd2;
   localparam logic [FIELD_W-1:0] LEN_C_RESET = 13'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_RD_B,
      ST_RD_C,
      ST_WRITE,
      ST_DONE
   } state_type;

endpackage

@@ sv/max_segment_cut_count.sv @@
// Segment cut counter: fills a count table bottom-up, one entry at a time.
// Each entry passes through the states RD_B, RD_C and WRITE; a total_length beyond
// MAX_LEN goes straight to DONE with a zero result. The next word is taken only when
// idle again, later while a result stalls; one write and one read port on the table.
// Reset (synchronous, high) idles the sequencer and sets the lengths to 1, 2, 3.
// Depends on mscc_pkg and assert_macros.svh; the table needs no clearing.
`include "assert_macros.svh"

module max_segment_cut_count #(
   parameter int MAX_LEN = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   // Input stream; tdata fields from bit 0: total_length[12:0], zero pad
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [mscc_pkg::DATA_W-1:0]     req_tdata,
   // Result stream; tdata fields from bit 0: piece_count[12:0], zero pad
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mscc_pkg::DATA_W-1:0]     rsp_tdata,
   // Configuration writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mscc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mscc_pkg::FIELD_W-1:0]    csr_data
);
   import mscc_pkg::*;

   localparam int IDX_W = $clog2(MAX_LEN + 1);
   localparam int CNT_W = IDX_W;
   localparam logic [31:0] MAX_LEN_U = 32'(MAX_LEN);

   typedef struct packed {
      logic             reach;
      logic [CNT_W-1:0] cnt;
   } entry_type;

   localparam int ENT_W = $bits(entry_type);

   // Table memory
   logic [ENT_W-1:0] mem [0:MAX_LEN];

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] tgt_ff, tgt_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [FIELD_W-1:0] len_a_ff, len_b_ff, len_c_ff;
   logic             ok_ff, ok_in;
   logic [CNT_W-1:0] best_ff, best_in;
   logic             use_ff, use_in;
   logic             byp_ff, byp_in;
   entry_type        byp_data_ff;
   entry_type        mem_q_ff;
   logic [CNT_W-1:0] res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0] rsp_data_ff, rsp_data_in;

   logic [FIELD_W-1:0] n_word;
   logic             issue_a;
   logic [31:0]      j_rd;
   logic [FIELD_W-1:0] off_len;
   logic             rd_use;
   logic [IDX_W-1:0] rd_addr;
   logic             mem_we;
   entry_type        wr_data;
   entry_type        data_sel;
   logic             base_ok;
   logic [CNT_W-1:0] base_best;
   logic [CNT_W-1:0] cand;
   logic             take;
   logic             new_ok;
   logic [CNT_W-1:0] new_best;

   assign n_word     = req_tdata[FIELD_W-1:0];
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(DATA_W-FIELD_W){1'b0}}, rsp_data_ff};

   // Pick the offset and entry for this cycle's table read
   always_comb begin
      issue_a = (state_ff == ST_INIT) || (state_ff == ST_WRITE);
      j_rd    = 32'(idx_ff) + (issue_a ? 32'd1 : 32'd0);
      case (state_ff)
         ST_RD_B: off_len = len_b_ff;
         ST_RD_C: off_len = len_c_ff;
         default: off_len = len_a_ff;
      endcase
      rd_use  = (off_len != '0) && (32'(off_len) <= j_rd);
      rd_addr = IDX_W'(j_rd - 32'(off_len));
   end

   // Shared combine unit: fold one predecessor into the running best
   always_comb begin
      data_sel  = byp_ff ? byp_data_ff : mem_q_ff;
      base_ok   = (state_ff == ST_RD_B) ? 1'b0 : ok_ff;
      base_best = (state_ff == ST_RD_B) ? '0 : best_ff;
      cand      = data_sel.cnt + CNT_W'(1);
      take      = use_ff && data_sel.reach && (!base_ok || (cand > base_best));
      new_ok    = base_ok | take;
      new_best  = take ? cand : base_best;
   end

   // Table write: entry 0 on init, entry idx on write
   always_comb begin
      mem_we = issue_a;
      if (state_ff == ST_INIT) begin
         wr_data.reach = 1'b1;
         wr_data.cnt   = '0;
      end else begin
         wr_data.reach = new_ok;
         wr_data.cnt   = new_ok ? new_best : '0;
      end
      byp_in = mem_we && rd_use && (rd_addr == idx_ff);
      use_in = rd_use;
   end

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      tgt_in       = tgt_ff;
      idx_in       = idx_ff;
      ok_in        = ok_ff;
      best_in      = best_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (32'(n_word) > MAX_LEN_U) begin
                  res_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  tgt_in   = IDX_W'(n_word);
                  idx_in   = '0;
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            res_in = '0;
            ok_in  = 1'b0;
            if (tgt_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               idx_in   = IDX_W'(32'(idx_ff) + 32'd1);
               state_in = ST_RD_B;
            end
         end
         ST_RD_B: begin
            ok_in    = new_ok;
            best_in  = new_best;
            state_in = ST_RD_C;
         end
         ST_RD_C: begin
            ok_in    = new_ok;
            best_in  = new_best;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            ok_in  = 1'b0;
            res_in = wr_data.cnt;
            if (idx_ff == tgt_ff) begin
               state_in = ST_DONE;
            end else begin
               idx_in   = IDX_W'(32'(idx_ff) + 32'd1);
               state_in = ST_RD_B;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = FIELD_W'(res_ff);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ok_ff        <= 1'b0;
         use_ff       <= 1'b0;
         byp_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         len_a_ff     <= LEN_A_RESET;
         len_b_ff     <= LEN_B_RESET;
         len_c_ff     <= LEN_C_RESET;
      end else begin
         state_ff     <= state_in;
         ok_ff        <= ok_in;
         use_ff       <= use_in;
         byp_ff       <= byp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && (csr_index == CSR_PIECE_LEN_A)) begin
            len_a_ff <= csr_data;
         end
         if (csr_valid && (csr_index == CSR_PIECE_LEN_B)) begin
            len_b_ff <= csr_data;
         end
         if (csr_valid && (csr_index == CSR_PIECE_LEN_C)) begin
            len_c_ff <= csr_data;
         end
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      tgt_ff      <= tgt_in;
      idx_ff      <= idx_in;
      best_ff     <= best_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      byp_data_ff <= wr_data;
   end

   // Table: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[idx_ff] <= wr_data;
      end
      mem_q_ff <= mem[rd_addr];
   end

   `ASSERT_IMP(a_idx_in_range, (state_ff == ST_RD_B) || (state_ff == ST_WRITE),
      idx_ff <= tgt_ff, "entry index beyond target")
   `ASSERT_IMP(a_bypass_after_write, byp_ff, $past(mem_we), "bypass without a table write")
   `ASSERT_IMP(a_best_nonzero, ok_ff, best_ff != '0, "reachable entry with zero count")
   `ASSERT_IMP(a_done_from_work, $rose(state_ff == ST_DONE),
      $past(state_ff) != ST_RD_C, "done entered mid entry")

endmodule
